// File: hw/rtl/enr_pkg.sv
// Shared types, rotor wiring tables and modulo-26 helpers for the rotor stage.
package enr_pkg;

	// Alphabet and rotor bank size
	localparam logic [5:0] LETTERS    = 6'd26;
	localparam int         NUM_ROTORS = 5;
	localparam int         ADDR_W     = 3;
	localparam int         DATA_W     = 32;

	typedef logic [4:0] letter_t;
	typedef logic [2:0] rotor_sel_t;

	// Operation codes carried by the mode field
	typedef enum logic [1:0] {
		MODE_FWD    = 2'd0,
		MODE_BWD    = 2'd1,
		MODE_ROTATE = 2'd2,
		MODE_LOAD   = 2'd3
	} mode_t;

	// Register indexes (taken from paddr[2])
	localparam logic REG_ROTOR_SEL = 1'b0;
	localparam logic REG_RING      = 1'b1;

	// Configuration handed from the register block to the datapath
	typedef struct packed {
		rotor_sel_t rotor_sel;
		letter_t    ring;
	} cfg_t;

	// Forward wirings, rotors I..V
	localparam letter_t WIRE_FWD [NUM_ROTORS][26] = '{
		'{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19,
		  5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17,
		  5'd2, 5'd9},
		'{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7,
		  5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21,
		  5'd14, 5'd4},
		'{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21,
		  5'd25, 5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18,
		  5'd16, 5'd14},
		'{5'd4, 5'd18, 5'd14, 5'd21, 5'd15, 5'd25, 5'd9, 5'd0, 5'd24, 5'd16, 5'd20, 5'd8,
		  5'd17, 5'd7, 5'd23, 5'd11, 5'd13, 5'd5, 5'd19, 5'd6, 5'd10, 5'd3, 5'd2, 5'd12,
		  5'd22, 5'd1},
		'{5'd21, 5'd25, 5'd1, 5'd17, 5'd6, 5'd8, 5'd19, 5'd24, 5'd20, 5'd15, 5'd18, 5'd3,
		  5'd13, 5'd7, 5'd11, 5'd23, 5'd0, 5'd22, 5'd12, 5'd9, 5'd16, 5'd14, 5'd5, 5'd4,
		  5'd2, 5'd10}
	};

	// Inverse wirings, rotors I..V
	localparam letter_t WIRE_INV [NUM_ROTORS][26] = '{
		'{5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4,
		  5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16,
		  5'd14, 5'd9},
		'{5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10,
		  5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8,
		  5'd21, 5'd18},
		'{5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5,
		  5'd21, 5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10,
		  5'd14, 5'd12},
		'{5'd7, 5'd25, 5'd22, 5'd21, 5'd0, 5'd17, 5'd19, 5'd13, 5'd11, 5'd6, 5'd20, 5'd15,
		  5'd23, 5'd16, 5'd2, 5'd4, 5'd9, 5'd12, 5'd1, 5'd18, 5'd10, 5'd3, 5'd24, 5'd14,
		  5'd8, 5'd5},
		'{5'd16, 5'd2, 5'd24, 5'd11, 5'd23, 5'd22, 5'd4, 5'd13, 5'd5, 5'd19, 5'd25, 5'd14,
		  5'd18, 5'd12, 5'd21, 5'd9, 5'd20, 5'd3, 5'd10, 5'd6, 5'd8, 5'd0, 5'd17, 5'd15,
		  5'd7, 5'd1}
	};

	// Turnover letters Q, E, V, J, Z
	localparam letter_t NOTCH [NUM_ROTORS] = '{5'd16, 5'd4, 5'd21, 5'd9, 5'd25};

	// Out-of-range selects fall back to rotor I
	function automatic rotor_sel_t rotor_index(input rotor_sel_t sel);
		return (sel < rotor_sel_t'(NUM_ROTORS)) ? sel : '0;
	endfunction

	// Fold a 5-bit value into 0..25
	function automatic letter_t reduce26(input letter_t a);
		return (a >= letter_t'(LETTERS)) ? letter_t'(a - letter_t'(LETTERS)) : a;
	endfunction

	// (a + b) mod 26, both operands in 0..25
	function automatic letter_t add_mod26(input letter_t a, input letter_t b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= LETTERS) ? letter_t'(s - LETTERS) : letter_t'(s);
	endfunction

	// (a - b) mod 26, both operands in 0..25
	function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
		logic [5:0] d;
		d = {1'b0, a} + LETTERS - {1'b0, b};
		return (d >= LETTERS) ? letter_t'(d - LETTERS) : letter_t'(d);
	endfunction

	function automatic letter_t notch_of(input rotor_sel_t sel);
		return NOTCH[rotor_index(sel)];
	endfunction

endpackage

// File: hw/rtl/enr_regs.sv
// APB register block: rotor select and ring setting.
module enr_regs import enr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	output cfg_t                cfg
);

	rotor_sel_t rotor_sel_q;
	letter_t    ring_q;
	logic       wr_en;
	logic       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_sel_q <= '0;
			ring_q      <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROTOR_SEL: rotor_sel_q <= pwdata[2:0];
				REG_RING:      ring_q      <= pwdata[4:0];
				default:       ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ROTOR_SEL: prdata = DATA_W'(rotor_sel_q);
			REG_RING:      prdata = DATA_W'(ring_q);
			default:       prdata = '0;
		endcase
	end

	assign cfg.rotor_sel = rotor_sel_q;
	assign cfg.ring      = ring_q;

endmodule

// File: hw/rtl/enr_subst.sv
// Single-pass substitution through the selected wiring or its inverse.
module enr_subst import enr_pkg::*; (
	input  cfg_t    cfg,
	input  logic    backward,
	input  letter_t letter,
	input  letter_t position,
	output letter_t letter_out
);

	rotor_sel_t sel;
	letter_t    ring;
	letter_t    shifted;
	letter_t    idx;
	letter_t    wired;

	assign sel  = rotor_index(cfg.rotor_sel);
	assign ring = reduce26(cfg.ring);

	// Entry contact: letter + position - ring
	assign shifted = add_mod26(letter, position);
	assign idx     = sub_mod26(shifted, ring);

	// Table lookup
	assign wired = backward ? WIRE_INV[sel][idx] : WIRE_FWD[sel][idx];

	// Exit contact: wired + ring - position
	assign letter_out = sub_mod26(add_mod26(wired, ring), position);

endmodule

// File: hw/rtl/enigma_rotor_substitution.sv
// Enigma rotor stage: one item per cycle unless the output stalls. Each beat
// is captured in an input register, runs through one pass of modulo-26
// arithmetic and a wiring table lookup, and lands in a result register; the
// rotor position register is updated in the same cycle, so the next beat
// sees the new position at once. The result register frees a slot whenever
// the downstream side takes its beat, so a stalled result holds back at most
// one further item in the input register.
module enigma_rotor_substitution import enr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic [4:0]          letter_in,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          letter_out,
	output logic [4:0]          rotor_position,
	output logic                at_notch
);

	cfg_t    cfg;
	logic    valid_s1;
	mode_t   mode_s1;
	letter_t letter_s1;
	logic    out_valid_q;
	letter_t letter_out_q;
	letter_t position_out_q;
	logic    at_notch_q;
	letter_t position_q;
	letter_t position_nxt;
	letter_t subst_letter;
	logic    accept_in;
	logic    advance_s1;
	logic    is_pass;

	enr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: stage 1 moves on when the result register is free or drains
	assign advance_s1 = valid_s1 & (~out_valid_q | ~out_stall);
	assign in_stall   = valid_s1 & ~advance_s1;
	assign accept_in  = in_valid & ~in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			mode_s1   <= mode_t'(mode);
			letter_s1 <= reduce26(letter_in);
		end
	end

	// Substitution pass
	assign is_pass = (mode_s1 == MODE_FWD) | (mode_s1 == MODE_BWD);

	enr_subst u_subst (
		.cfg        (cfg),
		.backward   (mode_s1 == MODE_BWD),
		.letter     (letter_s1),
		.position   (position_q),
		.letter_out (subst_letter)
	);

	// Position update
	always_comb begin
		position_nxt = position_q;
		unique case (mode_s1)
			MODE_ROTATE: position_nxt = (position_q == letter_t'(LETTERS - 6'd1)) ?
			                            '0 : letter_t'(position_q + 5'd1);
			MODE_LOAD:   position_nxt = letter_s1;
			default:     position_nxt = position_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (advance_s1) begin
			position_q <= position_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			letter_out_q   <= is_pass ? subst_letter : '0;
			position_out_q <= position_nxt;
			at_notch_q     <= (position_nxt == notch_of(cfg.rotor_sel));
		end
	end

	assign out_valid      = out_valid_q;
	assign letter_out     = letter_out_q;
	assign rotor_position = position_out_q;
	assign at_notch       = at_notch_q;

`ifndef SYNTHESIS
	// Position never leaves the alphabet
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		position_q < letter_t'(LETTERS))
		else $error("rotor position out of range");

	// A waiting result always reports the live position
	a_out_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (position_out_q == position_q))
		else $error("result position differs from position register");

	// Rotate and load beats carry a zero letter
	a_zero_letter: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && (mode_s1 == MODE_ROTATE || mode_s1 == MODE_LOAD)) |=>
		(letter_out_q == '0))
		else $error("nonzero letter on rotate or load beat");

	// Rotate steps the position by one with wrap
	a_rotate: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && mode_s1 == MODE_ROTATE) |=>
		(position_q == (($past(position_q) == letter_t'(LETTERS - 6'd1)) ?
		 letter_t'(0) : letter_t'($past(position_q) + 5'd1))))
		else $error("rotate did not advance position");

	// An empty input register never holds off the sender
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall raised with empty input register");
`endif

endmodule
